/* src/tdcu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdcu_pkg
// Types and codes shared by the TDC sub-subevent word unpacker.
// ----------------------------------------------------------------------------
package tdcu_pkg;

  typedef enum logic [2:0] {
    KIND_BLOCK   = 3'd0,
    KIND_HIT     = 3'd1,
    KIND_TDC_HDR = 3'd2,
    KIND_TDC_TRL = 3'd3,
    KIND_DEBUG   = 3'd4,
    KIND_EPOCH   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_TRAILER_IDLE = 2'd1,
    ERR_HEADER_OPEN  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    MARK_TRAILER = 2'd0,
    MARK_HEADER  = 2'd1,
    MARK_DEBUG   = 2'd2,
    MARK_EPOCH   = 2'd3
  } marker_t;

  typedef struct packed {
    logic [31:0] word;
    logic        restart;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    err_t        error;
    logic [15:0] source_id;
    logic [15:0] block_length;
    logic [6:0]  channel;
    logic        edge_res;
    logic [27:0] epoch;
    logic [10:0] coarse;
    logic [9:0]  fine;
  } out_t;

endpackage

/* src/tdc_subsubevent_word_unpacker_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_subsubevent_word_unpacker_top
// Decodes TDC sub-subevent words into block headers, hits, TDC headers,
// trailers, debug and epoch words, one result per word.
// ----------------------------------------------------------------------------
// One word is taken per clock while in_stall is low and gives one result: the word
// lands in an input register, is decoded against the block state (words left,
// source, epoch, TDC open) and lands in the result register, where the state
// is updated in the same edge. The result register lets a new word enter
// while an earlier result waits behind out_stall.
module tdc_subsubevent_word_unpacker_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tdcu_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tdcu_pkg::out_t out_data
);
  import tdcu_pkg::*;

  logic        s1_valid;
  in_t         s1_data;
  logic        out_adv;
  logic        s1_adv;
  logic        s1_move;

  logic [15:0] words_left;
  logic [15:0] words_left_next;
  logic [15:0] current_source;
  logic [15:0] current_source_next;
  logic [27:0] epoch_count;
  logic [27:0] epoch_count_next;
  logic        tdc_open;
  logic        tdc_open_next;
  out_t        res;
  logic        is_header;

  assign out_adv  = !out_valid || !out_stall;
  assign s1_adv   = !s1_valid || out_adv;
  assign in_stall = !s1_adv;
  assign s1_move  = s1_valid && out_adv;

  assign is_header = s1_data.restart || (words_left == 16'd0);

  always_comb begin
    res                 = '0;
    res.kind            = KIND_BLOCK;
    res.error           = ERR_NONE;
    words_left_next     = words_left;
    current_source_next = current_source;
    epoch_count_next    = epoch_count;
    tdc_open_next       = tdc_open;
    if (is_header) begin
      res.block_length    = s1_data.word[31:16];
      words_left_next     = s1_data.word[31:16];
      current_source_next = s1_data.word[15:0];
      epoch_count_next    = '0;
      tdc_open_next       = 1'b0;
    end else begin
      words_left_next = words_left - 16'd1;
      if (s1_data.word[31]) begin
        res.kind     = KIND_HIT;
        res.channel  = s1_data.word[28:22];
        res.fine     = s1_data.word[21:12];
        res.edge_res = s1_data.word[11];
        res.coarse   = s1_data.word[10:0];
        res.epoch    = epoch_count;
      end else begin
        unique case (marker_t'(s1_data.word[30:29]))
          MARK_TRAILER: begin
            res.kind = KIND_TDC_TRL;
            if (tdc_open) tdc_open_next = 1'b0;
            else res.error = ERR_TRAILER_IDLE;
          end
          MARK_HEADER: begin
            res.kind = KIND_TDC_HDR;
            if (!tdc_open) tdc_open_next = 1'b1;
            else res.error = ERR_HEADER_OPEN;
          end
          MARK_DEBUG: begin
            res.kind = KIND_DEBUG;
          end
          default: begin
            res.kind         = KIND_EPOCH;
            epoch_count_next = s1_data.word[27:0];
            res.epoch        = s1_data.word[27:0];
          end
        endcase
      end
    end
    res.source_id = current_source_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      words_left     <= '0;
      current_source <= '0;
      epoch_count    <= '0;
      tdc_open       <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= in_valid;
      if (out_adv) out_valid <= s1_valid;
      if (s1_move) begin
        words_left     <= words_left_next;
        current_source <= current_source_next;
        epoch_count    <= epoch_count_next;
        tdc_open       <= tdc_open_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) s1_data <= in_data;
    if (s1_move) out_data <= res;
  end

  a_hdr_clears: assert property (@(posedge clk) disable iff (rst)
    s1_move && is_header |=> !tdc_open && (epoch_count == 28'd0))
    else $error("block header did not clear epoch and open flag");

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && out_stall |-> in_stall)
    else $error("input taken while both registers are held");

  a_hdr_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_BLOCK) |-> (out_data.error == ERR_NONE))
    else $error("block header result carries an error");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.error != ERR_NONE) |->
      (out_data.kind == KIND_TDC_TRL) || (out_data.kind == KIND_TDC_HDR))
    else $error("error on a word that is neither TDC header nor trailer");

endmodule

/* bench/tdc_subsubevent_word_unpacker_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdc_subsubevent_word_unpacker_top_test
// Self-checking bench for the TDC sub-subevent word unpacker.
// ----------------------------------------------------------------------------
// A queue of words is built up front: a directed opening (header from reset,
// zero length block, restart in mid block, TDC header while open, trailer
// while closed, all-ones and all-zero hits, epoch extremes), then mostly
// well-formed blocks with random content mixed with truncated blocks and
// noise. A driver offers the words with random gaps, a monitor stalls the
// output at random and once for a long stretch, and every result transfer is
// checked field by field against a decoder kept in the bench.
// ----------------------------------------------------------------------------
module tdc_subsubevent_word_unpacker_top_test;
  import tdcu_pkg::*;

  localparam int RANDOM_WORDS = 500;
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic hold_off = 1'b0;

  in_t  word_q[$];
  out_t result_q[$];

  logic [15:0] words_left;
  logic [15:0] cur_source;
  logic [27:0] epoch_cnt;
  logic        tdc_open;

  int total_words = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int mismatches = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;
  int kind_seen[6];
  int err_seen[3];
  out_t want;

  tdc_subsubevent_word_unpacker_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic out_t decode_word(in_t it);
    out_t r;
    marker_t mk;
    r = '0;
    if (it.restart || words_left == 16'd0) begin
      r.kind = KIND_BLOCK;
      r.block_length = it.word[31:16];
      words_left = it.word[31:16];
      cur_source = it.word[15:0];
      epoch_cnt = '0;
      tdc_open = 1'b0;
    end else begin
      words_left = words_left - 16'd1;
      if (it.word[31]) begin
        r.kind = KIND_HIT;
        r.channel = it.word[28:22];
        r.fine = it.word[21:12];
        r.edge_res = it.word[11];
        r.coarse = it.word[10:0];
        r.epoch = epoch_cnt;
      end else begin
        mk = marker_t'(it.word[30:29]);
        case (mk)
          MARK_TRAILER: begin
            r.kind = KIND_TDC_TRL;
            if (tdc_open) tdc_open = 1'b0;
            else r.error = ERR_TRAILER_IDLE;
          end
          MARK_HEADER: begin
            r.kind = KIND_TDC_HDR;
            if (!tdc_open) tdc_open = 1'b1;
            else r.error = ERR_HEADER_OPEN;
          end
          MARK_DEBUG: r.kind = KIND_DEBUG;
          default: begin
            r.kind = KIND_EPOCH;
            epoch_cnt = it.word[27:0];
            r.epoch = epoch_cnt;
          end
        endcase
      end
    end
    r.source_id = cur_source;
    return r;
  endfunction

  function automatic string show(out_t r);
    return $sformatf("kind=%0d err=%0d src=%h len=%h ch=%0d edge=%0d epoch=%h coarse=%h fine=%h",
                     r.kind, r.error, r.source_id, r.block_length, r.channel, r.edge_res,
                     r.epoch, r.coarse, r.fine);
  endfunction

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic add_word(logic [31:0] w, logic rs);
    in_t it;
    it.word = w;
    it.restart = rs;
    word_q.push_back(it);
  endtask

  function automatic logic [31:0] body_word(int sel);
    logic [31:0] w;
    w = $urandom();
    case (sel)
      0: w[31] = 1'b1;
      1: w[31:29] = {1'b0, MARK_HEADER};
      2: w[31:29] = {1'b0, MARK_TRAILER};
      3: w[31:29] = {1'b0, MARK_DEBUG};
      default: w[31:29] = {1'b0, MARK_EPOCH};
    endcase
    return w;
  endfunction

  // Well-formed block: TDC header, then hits, epochs, debug words and some stray TDC headers
  // or trailers, then a trailer. A truncated block stops early; a following block restarts.
  task automatic add_block(logic rs, bit cut);
    int len;
    int n;
    int r;
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 10);
    add_word({len[15:0], 16'($urandom())}, rs);
    n = cut ? $urandom_range(0, len) : len;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (i == 0) add_word(body_word(1), 1'b0);
      else if (i == len - 1) add_word(body_word(2), 1'b0);
      else if (r < 65) add_word(body_word(0), 1'b0);
      else if (r < 85) add_word(body_word(4), 1'b0);
      else if (r < 92) add_word(body_word(3), 1'b0);
      else add_word(body_word($urandom_range(1, 2)), 1'b0);
    end
  endtask

  initial begin
    bit force_rs;
    int r;
    int n;
    force_rs = 1'b0;
    add_word(32'h0006_FFFF, 1'b0);
    add_word(32'h2ABC_DEF0, 1'b0);
    add_word(32'h3FFF_FFFF, 1'b0);
    add_word(32'h7FFF_FFFF, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h4000_0000, 1'b0);
    add_word(32'h0000_0000, 1'b0);
    add_word(32'h0000_1234, 1'b0);
    add_word(32'h0004_0000, 1'b0);
    add_word(32'h1FFF_FFFF, 1'b0);
    add_word(32'h8000_0000, 1'b0);
    add_word(32'h6000_0000, 1'b0);
    add_word(32'hFFFF_ABCD, 1'b1);
    add_word(32'h6555_5555, 1'b0);
    add_word(32'hC000_0800, 1'b0);
    add_word(32'h5AAA_AAAA, 1'b0);
    add_word(32'h0002_0001, 1'b1);
    add_word(32'hBFFF_F7FF, 1'b0);
    add_word(32'h0000_0001, 1'b0);
    add_word(32'h0000_FFFF, 1'b1);
    add_word(32'hFFFF_0000, 1'b1);
    add_word(32'h0000_0000, 1'b1);
    while (word_q.size() < 22 + RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_block(force_rs | ($urandom_range(0, 3) == 0), 1'b0);
        force_rs = 1'b0;
      end else if (r < 90) begin
        add_block(force_rs | ($urandom_range(0, 3) == 0), 1'b1);
        force_rs = 1'b1;
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) add_word($urandom(), $urandom_range(0, 7) == 0);
        force_rs = 1'b1;
      end
    end
    total_words = word_q.size();
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      words_left = '0;
      cur_source = '0;
      epoch_cnt = '0;
      tdc_open = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        result_q.push_back(decode_word(in_data));
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || word_q.size() == 0) begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap <= in_gap - 1;
        end else begin
          in_data <= word_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= draw_gap(in_calm);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transfer: %s", show(out_data));
        end else begin
          want = result_q.pop_front();
          checked_cnt++;
          kind_seen[int'(want.kind)]++;
          err_seen[int'(want.error)]++;
          if (out_data.kind !== want.kind || out_data.error !== want.error ||
              out_data.source_id !== want.source_id ||
              out_data.block_length !== want.block_length ||
              out_data.channel !== want.channel || out_data.edge_res !== want.edge_res ||
              out_data.epoch !== want.epoch || out_data.coarse !== want.coarse ||
              out_data.fine !== want.fine) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d", checked_cnt);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(out_data));
            end
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall <= hold_off;
        if (out_valid && !out_stall) out_gap <= draw_gap(out_calm);
      end
    end
  end

  // long output hold-off so the input side backs up
  initial begin
    wait (!rst && sent_cnt >= 120);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    wait (!rst && total_words > 0 && sent_cnt == total_words);
    wait (result_q.size() == 0);
    repeat (20) @(posedge clk);
    $display("%0d words decoded: %0d block headers, %0d hits, %0d tdc headers, %0d trailers",
             checked_cnt, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
    $display("%0d debug, %0d epoch words; %0d closed trailers, %0d repeated headers",
             kind_seen[4], kind_seen[5], err_seen[1], err_seen[2]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", result_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
